FILE: rtl/core/quaternion_to_rotation_matrix_defines.svh
// Assertion macros shared by the quaternion to rotation matrix RTL.
`ifndef QUATERNION_TO_ROTATION_MATRIX_DEFINES_SVH
`define QUATERNION_TO_ROTATION_MATRIX_DEFINES_SVH

// Clocked check, masked while reset is high.
`define QRM_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("quaternion_to_rotation_matrix assertion failed");

// Clocked check that also holds during reset.
`define QRM_ASSERT_NR(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("quaternion_to_rotation_matrix assertion failed");

`endif

FILE: rtl/core/qrm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrm_pkg
// Lane numbering and shared constants of the quaternion to matrix pipeline.
// ----------------------------------------------------------------------------
package qrm_pkg;

   // one divider lane per matrix entry, row major
   localparam int NumLanes = 9;
   localparam int LaneM00  = 0;
   localparam int LaneM01  = 1;
   localparam int LaneM02  = 2;
   localparam int LaneM10  = 3;
   localparam int LaneM11  = 4;
   localparam int LaneM12  = 5;
   localparam int LaneM20  = 6;
   localparam int LaneM21  = 7;
   localparam int LaneM22  = 8;

   // quaternion component order inside the pipeline
   localparam int CompX = 0;
   localparam int CompY = 1;
   localparam int CompZ = 2;
   localparam int CompW = 3;

   // cross products: xy, xz, yz, wx, wy, wz
   localparam int PrXY = 0;
   localparam int PrXZ = 1;
   localparam int PrYZ = 2;
   localparam int PrWX = 3;
   localparam int PrWY = 4;
   localparam int PrWZ = 5;

endpackage

FILE: rtl/core/qrm_div_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrm_div_stage
// One restoring division step for all nine lanes, registered, with handshake.
// ----------------------------------------------------------------------------
module qrm_div_stage #(
   parameter int DATA_WIDTH = 16,
   parameter bit SHIFT      = 1'b1
) (
   input  logic                                                  clock,
   input  logic                                                  reset,
   input  logic                                                  in_valid,
   output logic                                                  in_ready,
   input  logic [qrm_pkg::NumLanes-1:0][2*DATA_WIDTH+1:0]         in_rem,
   input  logic [qrm_pkg::NumLanes-1:0][DATA_WIDTH-1:0]           in_quo,
   input  logic [2*DATA_WIDTH:0]                                  in_den,
   input  logic [qrm_pkg::NumLanes-1:0]                           in_neg,
   input  logic                                                  in_zero,
   output logic                                                  out_valid,
   input  logic                                                  out_ready,
   output logic [qrm_pkg::NumLanes-1:0][2*DATA_WIDTH+1:0]         out_rem,
   output logic [qrm_pkg::NumLanes-1:0][DATA_WIDTH-1:0]           out_quo,
   output logic [2*DATA_WIDTH:0]                                  out_den,
   output logic [qrm_pkg::NumLanes-1:0]                           out_neg,
   output logic                                                  out_zero
);

   localparam int W  = DATA_WIDTH;
   localparam int RW = 2 * W + 2;

   logic                                        valid_ff;
   logic [qrm_pkg::NumLanes-1:0][RW-1:0]        rem_ff, rem_in;
   logic [qrm_pkg::NumLanes-1:0][W-1:0]         quo_ff, quo_in;
   logic [2*W:0]                                den_ff;
   logic [qrm_pkg::NumLanes-1:0]                neg_ff;
   logic                                        zero_ff;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      logic [RW-1:0] part;
      logic          ge;
      for (int i = 0; i < qrm_pkg::NumLanes; i++) begin
         part = SHIFT ? {in_rem[i][RW-2:0], 1'b0} : in_rem[i];
         ge = part >= {1'b0, in_den};
         rem_in[i] = ge ? part - {1'b0, in_den} : part;
         quo_in[i] = {in_quo[i][W-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         rem_ff  <= rem_in;
         quo_ff  <= quo_in;
         den_ff  <= in_den;
         neg_ff  <= in_neg;
         zero_ff <= in_zero;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_quo   = quo_ff;
   assign out_den   = den_ff;
   assign out_neg   = neg_ff;
   assign out_zero  = zero_ff;

endmodule

FILE: rtl/core/quaternion_to_rotation_matrix.sv
`timescale 1ns / 1ps
// Path: sign, product, numerator and magnitude stages, divider chain and
//   output register; a stall on the result side holds the pipeline.
// Throughput: one quaternion per cycle while the result side accepts; the
//   restoring divider is one pipeline stage per quotient bit, nine lanes wide.
// Reset: synchronous, active high; clears all stage valid bits.
`include "quaternion_to_rotation_matrix_defines.svh"
// ----------------------------------------------------------------------------
// quaternion_to_rotation_matrix
// Normalizes a Q2.14 quaternion by its squared norm and gives the rotation
// matrix, rounded and saturated; a zero quaternion gives the identity.
// ----------------------------------------------------------------------------
module quaternion_to_rotation_matrix #(
   parameter int DATA_WIDTH = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [DATA_WIDTH-1:0] req_quat_x,
   input  logic signed [DATA_WIDTH-1:0] req_quat_y,
   input  logic signed [DATA_WIDTH-1:0] req_quat_z,
   input  logic signed [DATA_WIDTH-1:0] req_quat_w,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [DATA_WIDTH-1:0] rsp_m00,
   output logic signed [DATA_WIDTH-1:0] rsp_m01,
   output logic signed [DATA_WIDTH-1:0] rsp_m02,
   output logic signed [DATA_WIDTH-1:0] rsp_m10,
   output logic signed [DATA_WIDTH-1:0] rsp_m11,
   output logic signed [DATA_WIDTH-1:0] rsp_m12,
   output logic signed [DATA_WIDTH-1:0] rsp_m20,
   output logic signed [DATA_WIDTH-1:0] rsp_m21,
   output logic signed [DATA_WIDTH-1:0] rsp_m22,
   output logic                         rsp_zero_norm
);

   localparam int W  = DATA_WIDTH;
   localparam int PW = 2 * W;
   localparam int SW = 2 * W + 1;
   localparam int RW = 2 * W + 2;
   localparam int FB = W - 2;
   localparam int NL = qrm_pkg::NumLanes;

   localparam logic [W-1:0]        One   = W'(1) << FB;
   localparam logic signed [W-1:0] OneS  = W'(1) << FB;
   localparam logic [W-1:0]        Lim   = W'(1) << (W - 1);
   localparam logic [W-1:0]        LimM1 = Lim - W'(1);

   // stage 1: sign and magnitude
   logic                  s1_valid_ff, s1_ready;
   logic [3:0][W-1:0]     s1_mag_ff, s1_mag_in;
   logic [3:0]            s1_neg_ff, s1_neg_in;
   logic [3:0][W-1:0]     quat_in;

   // stage 2: products
   logic                  s2_valid_ff, s2_ready;
   logic [3:0][PW-1:0]    s2_sq_ff;
   logic [5:0][PW-1:0]    s2_pr_ff;
   logic [5:0]            s2_pneg_ff;
   logic                  s2_zero_ff;

   // stage 3: signed numerators and squared norm
   logic                  s3_valid_ff, s3_ready;
   logic [NL-1:0][RW-1:0] s3_val_ff, s3_val_in;
   logic [SW-1:0]         s3_den_ff;
   logic                  s3_zero_ff;

   // stage 4: numerator magnitudes
   logic                  s4_valid_ff, s4_ready;
   logic [NL-1:0][RW-1:0] s4_rem_ff, s4_rem_in;
   logic [NL-1:0]         s4_neg_ff, s4_neg_in;
   logic [SW-1:0]         s4_den_ff;
   logic                  s4_zero_ff;

   // divider chain, index 0 is fed by stage 4
   logic                  dv_valid [W+1];
   logic                  dv_ready [W+1];
   logic [NL-1:0][RW-1:0] dv_rem   [W+1];
   logic [NL-1:0][W-1:0]  dv_quo   [W+1];
   logic [SW-1:0]         dv_den   [W+1];
   logic [NL-1:0]         dv_neg   [W+1];
   logic                  dv_zero  [W+1];

   // output register
   logic                  rsp_valid_ff, out_ready;
   logic [NL-1:0][W-1:0]  rsp_m_ff, rsp_m_in;
   logic                  rsp_zero_ff;

   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign s3_ready  = !s3_valid_ff || s4_ready;
   assign s4_ready  = !s4_valid_ff || dv_ready[0];
   assign out_ready = !rsp_valid_ff || rsp_ready;
   assign req_ready = s1_ready;

   // ---------------- stage 1 ----------------
   assign quat_in[qrm_pkg::CompX] = req_quat_x;
   assign quat_in[qrm_pkg::CompY] = req_quat_y;
   assign quat_in[qrm_pkg::CompZ] = req_quat_z;
   assign quat_in[qrm_pkg::CompW] = req_quat_w;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         s1_neg_in[i] = quat_in[i][W-1];
         // most negative code maps to 2^(W-1), still fits unsigned
         s1_mag_in[i] = quat_in[i][W-1] ? (~quat_in[i] + W'(1)) : quat_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= req_valid;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_ready) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (s4_ready) begin
            s4_valid_ff <= s3_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && req_valid) begin
         s1_mag_ff <= s1_mag_in;
         s1_neg_ff <= s1_neg_in;
      end
   end

   // ---------------- stage 2 ----------------
   always_ff @(posedge clock) begin
      if (s2_ready && s1_valid_ff) begin
         for (int i = 0; i < 4; i++) begin
            s2_sq_ff[i] <= PW'(s1_mag_ff[i]) * PW'(s1_mag_ff[i]);
         end
         s2_pr_ff[qrm_pkg::PrXY] <= PW'(s1_mag_ff[qrm_pkg::CompX]) * PW'(s1_mag_ff[qrm_pkg::CompY]);
         s2_pr_ff[qrm_pkg::PrXZ] <= PW'(s1_mag_ff[qrm_pkg::CompX]) * PW'(s1_mag_ff[qrm_pkg::CompZ]);
         s2_pr_ff[qrm_pkg::PrYZ] <= PW'(s1_mag_ff[qrm_pkg::CompY]) * PW'(s1_mag_ff[qrm_pkg::CompZ]);
         s2_pr_ff[qrm_pkg::PrWX] <= PW'(s1_mag_ff[qrm_pkg::CompW]) * PW'(s1_mag_ff[qrm_pkg::CompX]);
         s2_pr_ff[qrm_pkg::PrWY] <= PW'(s1_mag_ff[qrm_pkg::CompW]) * PW'(s1_mag_ff[qrm_pkg::CompY]);
         s2_pr_ff[qrm_pkg::PrWZ] <= PW'(s1_mag_ff[qrm_pkg::CompW]) * PW'(s1_mag_ff[qrm_pkg::CompZ]);
         s2_pneg_ff[qrm_pkg::PrXY] <= s1_neg_ff[qrm_pkg::CompX] ^ s1_neg_ff[qrm_pkg::CompY];
         s2_pneg_ff[qrm_pkg::PrXZ] <= s1_neg_ff[qrm_pkg::CompX] ^ s1_neg_ff[qrm_pkg::CompZ];
         s2_pneg_ff[qrm_pkg::PrYZ] <= s1_neg_ff[qrm_pkg::CompY] ^ s1_neg_ff[qrm_pkg::CompZ];
         s2_pneg_ff[qrm_pkg::PrWX] <= s1_neg_ff[qrm_pkg::CompW] ^ s1_neg_ff[qrm_pkg::CompX];
         s2_pneg_ff[qrm_pkg::PrWY] <= s1_neg_ff[qrm_pkg::CompW] ^ s1_neg_ff[qrm_pkg::CompY];
         s2_pneg_ff[qrm_pkg::PrWZ] <= s1_neg_ff[qrm_pkg::CompW] ^ s1_neg_ff[qrm_pkg::CompZ];
         s2_zero_ff <= (s1_mag_ff == '0);
      end
   end

   // ---------------- stage 3 ----------------
   always_comb begin
      logic [5:0][RW-1:0] term;
      logic [3:0][RW-1:0] sq;
      for (int i = 0; i < 6; i++) begin
         term[i] = s2_pneg_ff[i] ? (RW'(0) - RW'(s2_pr_ff[i])) : RW'(s2_pr_ff[i]);
      end
      for (int i = 0; i < 4; i++) begin
         sq[i] = RW'(s2_sq_ff[i]);
      end
      s3_val_in[qrm_pkg::LaneM00] = sq[qrm_pkg::CompW] + sq[qrm_pkg::CompX]
                                  - sq[qrm_pkg::CompY] - sq[qrm_pkg::CompZ];
      s3_val_in[qrm_pkg::LaneM11] = sq[qrm_pkg::CompW] + sq[qrm_pkg::CompY]
                                  - sq[qrm_pkg::CompX] - sq[qrm_pkg::CompZ];
      s3_val_in[qrm_pkg::LaneM22] = sq[qrm_pkg::CompW] + sq[qrm_pkg::CompZ]
                                  - sq[qrm_pkg::CompX] - sq[qrm_pkg::CompY];
      s3_val_in[qrm_pkg::LaneM01] = term[qrm_pkg::PrXY] - term[qrm_pkg::PrWZ];
      s3_val_in[qrm_pkg::LaneM02] = term[qrm_pkg::PrXZ] + term[qrm_pkg::PrWY];
      s3_val_in[qrm_pkg::LaneM10] = term[qrm_pkg::PrXY] + term[qrm_pkg::PrWZ];
      s3_val_in[qrm_pkg::LaneM12] = term[qrm_pkg::PrYZ] - term[qrm_pkg::PrWX];
      s3_val_in[qrm_pkg::LaneM20] = term[qrm_pkg::PrXZ] - term[qrm_pkg::PrWY];
      s3_val_in[qrm_pkg::LaneM21] = term[qrm_pkg::PrYZ] + term[qrm_pkg::PrWX];
   end

   always_ff @(posedge clock) begin
      if (s3_ready && s2_valid_ff) begin
         s3_val_ff  <= s3_val_in;
         s3_den_ff  <= SW'(s2_sq_ff[0]) + SW'(s2_sq_ff[1]) + SW'(s2_sq_ff[2])
                     + SW'(s2_sq_ff[3]);
         s3_zero_ff <= s2_zero_ff;
      end
   end

   // ---------------- stage 4 ----------------
   always_comb begin
      logic [RW-1:0] mag;
      for (int i = 0; i < NL; i++) begin
         s4_neg_in[i] = s3_val_ff[i][RW-1];
         mag = s3_val_ff[i][RW-1] ? (RW'(0) - s3_val_ff[i]) : s3_val_ff[i];
         // off-diagonal entries carry the factor of two
         if (i == qrm_pkg::LaneM00 || i == qrm_pkg::LaneM11 || i == qrm_pkg::LaneM22) begin
            s4_rem_in[i] = mag;
         end else begin
            s4_rem_in[i] = {mag[RW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s4_ready && s3_valid_ff) begin
         s4_rem_ff  <= s4_rem_in;
         s4_neg_ff  <= s4_neg_in;
         s4_den_ff  <= s3_den_ff;
         s4_zero_ff <= s3_zero_ff;
      end
   end

   // ---------------- divider ----------------
   assign dv_valid[0] = s4_valid_ff;
   assign dv_rem[0]   = s4_rem_ff;
   assign dv_quo[0]   = '0;
   assign dv_den[0]   = s4_den_ff;
   assign dv_neg[0]   = s4_neg_ff;
   assign dv_zero[0]  = s4_zero_ff;
   assign dv_ready[W] = out_ready;

   for (genvar k = 0; k < W; k++) begin : g_div
      qrm_div_stage #(
         .DATA_WIDTH (W),
         .SHIFT      (k != 0)
      ) u_step (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (dv_valid[k]),
         .in_ready  (dv_ready[k]),
         .in_rem    (dv_rem[k]),
         .in_quo    (dv_quo[k]),
         .in_den    (dv_den[k]),
         .in_neg    (dv_neg[k]),
         .in_zero   (dv_zero[k]),
         .out_valid (dv_valid[k+1]),
         .out_ready (dv_ready[k+1]),
         .out_rem   (dv_rem[k+1]),
         .out_quo   (dv_quo[k+1]),
         .out_den   (dv_den[k+1]),
         .out_neg   (dv_neg[k+1]),
         .out_zero  (dv_zero[k+1])
      );
   end

   // ---------------- round, saturate, output ----------------
   always_comb begin
      logic [W:0]   qp;
      logic [W-1:0] mag;
      for (int i = 0; i < NL; i++) begin
         // quotient holds one extra fraction bit: round half away from zero
         qp  = {1'b0, dv_quo[W][i]} + (W+1)'(1);
         mag = qp[W:1];
         if (!dv_neg[W][i] && mag > LimM1) begin
            mag = LimM1;
         end else if (dv_neg[W][i] && mag > Lim) begin
            mag = Lim;
         end
         rsp_m_in[i] = dv_neg[W][i] ? (~mag + W'(1)) : mag;
         if (dv_zero[W]) begin
            if (i == qrm_pkg::LaneM00 || i == qrm_pkg::LaneM11
                  || i == qrm_pkg::LaneM22) begin
               rsp_m_in[i] = One;
            end else begin
               rsp_m_in[i] = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= dv_valid[W];
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && dv_valid[W]) begin
         rsp_m_ff    <= rsp_m_in;
         rsp_zero_ff <= dv_zero[W];
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_m00       = rsp_m_ff[qrm_pkg::LaneM00];
   assign rsp_m01       = rsp_m_ff[qrm_pkg::LaneM01];
   assign rsp_m02       = rsp_m_ff[qrm_pkg::LaneM02];
   assign rsp_m10       = rsp_m_ff[qrm_pkg::LaneM10];
   assign rsp_m11       = rsp_m_ff[qrm_pkg::LaneM11];
   assign rsp_m12       = rsp_m_ff[qrm_pkg::LaneM12];
   assign rsp_m20       = rsp_m_ff[qrm_pkg::LaneM20];
   assign rsp_m21       = rsp_m_ff[qrm_pkg::LaneM21];
   assign rsp_m22       = rsp_m_ff[qrm_pkg::LaneM22];
   assign rsp_zero_norm = rsp_zero_ff;

   // ---------------- checks ----------------
   `QRM_ASSERT(a_zero_identity, clock, reset, rsp_valid && rsp_zero_norm |-> rsp_m00 == OneS && rsp_m11 == OneS && rsp_m22 == OneS && rsp_m01 == '0 && rsp_m12 == '0)
   `QRM_ASSERT(a_diag_unit_range, clock, reset, rsp_valid |-> rsp_m00 <= OneS && rsp_m00 >= -OneS && rsp_m22 <= OneS && rsp_m22 >= -OneS)
   `QRM_ASSERT(a_div_tail_holds, clock, reset, dv_valid[W] && !dv_ready[W] |=> dv_valid[W])
   `QRM_ASSERT_NR(a_reset_empties, clock, $past(reset) |-> !rsp_valid && !s1_valid_ff)

endmodule
